FILE: rtl/sml_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sml_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int CNT_W       = COUNT_WIDTH;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int BYTE_W      = 8;
  localparam int OUT_W       = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_LEN_W   = 5;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;
  localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] line_count;
    logic [LEN_W-1:0] nl;
    logic [CNT_W-1:0] start;
  } rec_t;

endpackage
`default_nettype wire

FILE: rtl/sml_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sml_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic [sml_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                             in_last_in_buffer,
  input  logic                             cfg_valid,
  input  logic [sml_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sml_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             q_full,
  output logic                             q_push,
  output sml_pkg::rec_t                    q_rec
);
  import sml_pkg::*;

  logic [BYTE_W-1:0]     win_r   [MAX_PATTERN];
  logic [BYTE_W-1:0]     win_nxt [MAX_PATTERN];
  logic [CFG_DATA_W-1:0] pat_low_r;
  logic [CFG_DATA_W-1:0] pat_high_r;
  logic [CFG_LEN_W-1:0]  pat_len_r;
  logic [CNT_W-1:0]      pos_r, lc_r, nas_r;
  logic [CNT_W-1:0]      pos_nxt, lc_nxt, nas_nxt;
  logic [LEN_W-1:0]      len_eff, len_m1, nl;
  logic [CNT_W-1:0]      start;
  logic [CNT_W:0]        nas_sum;
  logic                  accept, hit, bytes_eq;

  function automatic logic [BYTE_W-1:0] pat_byte(input logic [CFG_DATA_W-1:0] lo,
                                                 input logic [CFG_DATA_W-1:0] hi,
                                                 input logic [IDX_W-1:0] k);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (int'(k) < 8) begin
      b = lo[int'(k)*BYTE_W +: BYTE_W];
    end else if (int'(k) < 16) begin
      b = hi[(int'(k)-8)*BYTE_W +: BYTE_W];
    end
    return b;
  endfunction

  assign accept = in_push & ~q_full;

  always_comb begin
    int j;
    if (pat_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(pat_len_r) > MAX_PATTERN) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(pat_len_r);
    end
    len_m1 = len_eff - LEN_W'(1);

    win_nxt[0] = in_data_byte;
    for (j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = win_r[j-1];
    end

    bytes_eq = 1'b1;
    for (j = 0; j < MAX_PATTERN; j++) begin
      if (LEN_W'(j) < len_eff &&
          win_nxt[j] != pat_byte(pat_low_r, pat_high_r, IDX_W'(len_m1 - LEN_W'(j)))) begin
        bytes_eq = 1'b0;
      end
    end

    nl = '0;
    for (j = 0; j < MAX_PATTERN - 1; j++) begin
      if (LEN_W'(j) < len_m1 && win_nxt[j] == NEWLINE) begin
        nl = nl + LEN_W'(1);
      end
    end

    start = pos_r - CNT_W'(len_m1);
    hit   = (pos_r >= CNT_W'(len_m1)) && (start >= nas_r) && bytes_eq;

    lc_nxt = (in_data_byte == NEWLINE && lc_r != CNT_MAX) ? lc_r + CNT_W'(1) : lc_r;
    pos_nxt = (pos_r != CNT_MAX) ? pos_r + CNT_W'(1) : pos_r;
    nas_sum = {1'b0, start} + (CNT_W+1)'(len_eff);
    nas_nxt = nas_sum[CNT_W] ? CNT_MAX : nas_sum[CNT_W-1:0];
  end

  assign q_push         = accept & hit;
  assign q_rec.line_count = lc_nxt;
  assign q_rec.nl         = nl;
  assign q_rec.start      = start;

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= CFG_LEN_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PAT_LOW:  pat_low_r  <= cfg_data;
        CFG_PAT_HIGH: pat_high_r <= cfg_data;
        CFG_PAT_LEN:  pat_len_r  <= cfg_data[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      lc_r  <= CNT_W'(1);
      nas_r <= '0;
    end else if (accept) begin
      if (in_last_in_buffer) begin
        pos_r <= '0;
        lc_r  <= CNT_W'(1);
        nas_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        lc_r  <= lc_nxt;
        if (hit) begin
          nas_r <= nas_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sml_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sml_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sml_pkg::rec_t push_rec,
  output logic          full,
  input  logic          pop,
  output sml_pkg::rec_t pop_rec,
  output logic          empty
);
  import sml_pkg::*;

  rec_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              wr, rd;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign wr      = push & ~full;
  assign rd      = pop & ~empty;
  assign pop_rec = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + (QPTR_W+1)'(1);
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - (QPTR_W+1)'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !pop) |=> cnt_r == $past(cnt_r) + (QPTR_W+1)'(1))
    else $error("queue count did not rise on write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

FILE: rtl/sml_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sml_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  sml_pkg::rec_t              q_rec,
  output logic                       q_pop,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [sml_pkg::OUT_W-1:0]  out_match_line,
  output logic [sml_pkg::OUT_W-1:0]  out_match_offset
);
  import sml_pkg::*;

  logic             vld_r;
  logic [CNT_W-1:0] line_r, off_r;
  logic [CNT_W-1:0] line_nxt;
  logic             load;

  assign load  = ~q_empty & (~vld_r | out_pop);
  assign q_pop = load;

  // line of the first byte: step back over newlines inside the match
  assign line_nxt = (q_rec.line_count > CNT_W'(q_rec.nl)) ?
                    q_rec.line_count - CNT_W'(q_rec.nl) : CNT_W'(1);

  always_ff @(posedge clk) begin
    if (load) begin
      line_r <= line_nxt;
      off_r  <= q_rec.start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_pop) begin
      vld_r <= 1'b0;
    end
  end

  assign out_empty        = ~vld_r;
  assign out_match_line   = OUT_W'(line_r);
  assign out_match_offset = OUT_W'(off_r);

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> line_r != '0)
    else $error("reported line number is zero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_pop) |=> vld_r && $stable(line_r) && $stable(off_r))
    else $error("waiting item changed");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_pop) |-> !q_pop)
    else $error("queue drained into a full output stage");

endmodule
`default_nettype wire

FILE: rtl/substring_match_line_locator_core.sv
// an item that completes a match is written to the queue, then loaded into the output register once that is free
// throughput: one byte item per cycle while the queue is not full, set by the combinational window compare in the front
// a four-entry queue and an output register decouple the search from result pops
// reset (synchronous, rst_n low): offsets and start limit cleared, line count one,
// pattern bytes zero, pattern length one, queue and output empty
`timescale 1ns / 1ps
`default_nettype none
module substring_match_line_locator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [sml_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                              in_last_in_buffer,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [sml_pkg::OUT_W-1:0]         out_match_line,
  output logic [sml_pkg::OUT_W-1:0]         out_match_offset,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sml_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sml_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sml_pkg::*;

  rec_t push_rec, pop_rec;
  logic q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  sml_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_data_byte      (in_data_byte),
    .in_last_in_buffer (in_last_in_buffer),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_rec             (push_rec)
  );

  sml_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .empty    (q_empty)
  );

  sml_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rec            (pop_rec),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_match_line   (out_match_line),
    .out_match_offset (out_match_offset)
  );

endmodule
`default_nettype wire
